>>> rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and codes for the priority tick scheduler
// Field widths, result event codes, sequencer states and the task entry
// layout.
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRIO_W = 3;
  localparam int unsigned CYC_W  = 8;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned EV_W   = 3;

  // input command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // result event codes
  typedef enum logic [EV_W-1:0] {
    EV_ADDED    = 3'd0,
    EV_REJECTED = 3'd1,
    EV_SERVED   = 3'd2,
    EV_FINISHED = 3'd3,
    EV_IDLE     = 3'd4
  } event_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_UPDATE = 2'd2,
    ST_SHIFT  = 2'd3
  } state_t;

  // one task table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [CYC_W-1:0]  rem;
  } entry_t;

endpackage

>>> rtl/core/priority_tick_scheduler.sv
// ----------------------------------------------------------------------------
// priority_tick_scheduler: preemptive priority scheduler over a task table
// Tasks sit in arrival order in a single-port-read memory; one comparator
// walks the table on each tick and the same read/write ports close up the
// table when a task finishes.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge with start high and busy low. Every
// accepted word gives exactly one result word, shown for one cycle with
// out_valid high; the receiver must take it then, there is no back pressure.
// An add (in_command = 0) and a tick on an empty table are handled in the
// accept cycle: busy stays low and the result shows in the next cycle, so
// such words may come back to back. A tick on a non-empty table keeps busy
// high through the scan state (one memory read and one priority compare per
// entry), the update state and, when the served task finishes and is not the
// last entry, the shift state, which closes up the table by moving each entry
// behind it down by one (one memory read and one write per cycle). The result
// shows in the cycle busy drops. The table needs no clearing after reset:
// only entries below the task count are ever used.
// ----------------------------------------------------------------------------
module priority_tick_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [pts_pkg::ID_W-1:0]    in_task_id,
  input  logic [pts_pkg::PRIO_W-1:0]  in_task_priority,
  input  logic [pts_pkg::CYC_W-1:0]   in_task_cycles,
  // result channel
  output logic                        out_valid,
  output logic [pts_pkg::EV_W-1:0]    out_event_res,
  output logic [pts_pkg::ID_W-1:0]    out_served_id,
  output logic [pts_pkg::CYC_W-1:0]   out_remaining_cycles,
  output logic [pts_pkg::OCC_W-1:0]   out_occupancy
);

  // table index and task count widths
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  pts_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;      // entry now in rd_data_r during scan
  logic [AW-1:0]              best_pos_r, best_pos_nxt;
  logic [pts_pkg::PRIO_W-1:0] best_prio_r, best_prio_nxt;
  logic [pts_pkg::ID_W-1:0]   best_id_r, best_id_nxt;
  logic [pts_pkg::CYC_W-1:0]  best_rem_r, best_rem_nxt;

  logic                       out_valid_r, out_valid_nxt;
  pts_pkg::event_t            out_ev_r, out_ev_nxt;
  logic [pts_pkg::ID_W-1:0]   out_sid_r, out_sid_nxt;
  logic [pts_pkg::CYC_W-1:0]  out_rem_r, out_rem_nxt;
  logic [pts_pkg::OCC_W-1:0]  out_occ_r, out_occ_nxt;

  // task table memory: one write, one registered read per cycle
  pts_pkg::entry_t            mem [QUEUE_DEPTH];
  pts_pkg::entry_t            rd_data_r;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  pts_pkg::entry_t            wr_data;

  // ---------------------------------------------------------------------------
  // decode flags
  // ---------------------------------------------------------------------------
  logic                       accept;
  logic                       tbl_full;
  logic                       tbl_empty;
  logic [CW-1:0]              last_pos;     // count - 1
  logic                       scan_take;
  logic                       scan_last;
  logic [pts_pkg::CYC_W-1:0]  dec_rem;
  logic                       upd_keep;     // task still has cycles left
  logic                       upd_tail;     // served task is the last entry
  logic                       shift_last;

  assign accept     = start && (state_r == pts_pkg::ST_IDLE);
  assign tbl_full   = (count_r == CW'(QUEUE_DEPTH));
  assign tbl_empty  = (count_r == '0);
  assign last_pos   = count_r - CW'(1);

  // strict compare keeps the earliest arrival among equal priorities
  assign scan_take  = (idx_r == '0) || (rd_data_r.prio > best_prio_r);
  assign scan_last  = (CW'(idx_r) == last_pos);

  assign dec_rem    = (best_rem_r == '0) ? '0 : best_rem_r - pts_pkg::CYC_W'(1);
  assign upd_keep   = (dec_rem != '0);
  assign upd_tail   = (CW'(best_pos_r) == last_pos);

  assign shift_last = ((CW'(idx_r) + CW'(1)) == last_pos);

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pts_pkg::ST_IDLE: begin
        if (accept && (in_command == pts_pkg::CMD_TICK) && !tbl_empty) begin
          state_nxt = pts_pkg::ST_SCAN;
        end
      end
      pts_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = pts_pkg::ST_UPDATE;
        end
      end
      pts_pkg::ST_UPDATE: begin
        if (upd_keep || upd_tail) begin
          state_nxt = pts_pkg::ST_IDLE;
        end else begin
          state_nxt = pts_pkg::ST_SHIFT;
        end
      end
      pts_pkg::ST_SHIFT: begin
        if (shift_last) begin
          state_nxt = pts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pts_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath control and result words
  // ---------------------------------------------------------------------------
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    best_pos_nxt  = best_pos_r;
    best_prio_nxt = best_prio_r;
    best_id_nxt   = best_id_r;
    best_rem_nxt  = best_rem_r;
    rd_addr       = idx_r + AW'(1);
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = rd_data_r;
    out_valid_nxt = 1'b0;
    out_ev_nxt    = out_ev_r;
    out_sid_nxt   = '0;
    out_rem_nxt   = '0;

    case (state_r)
      pts_pkg::ST_IDLE: begin
        rd_addr = '0;  // entry 0 ready when the scan starts
        idx_nxt = '0;
        if (accept) begin
          out_valid_nxt = (in_command == pts_pkg::CMD_ADD) || tbl_empty;
          if (in_command == pts_pkg::CMD_ADD) begin
            if (tbl_full || (in_task_cycles == '0)) begin
              out_ev_nxt = pts_pkg::EV_REJECTED;
            end else begin
              // append at the tail; count < depth so it fits the index
              wr_en        = 1'b1;
              wr_addr      = count_r[AW-1:0];
              wr_data.id   = in_task_id;
              wr_data.prio = in_task_priority;
              wr_data.rem  = in_task_cycles;
              count_nxt    = count_r + CW'(1);
              out_ev_nxt   = pts_pkg::EV_ADDED;
            end
          end else if (tbl_empty) begin
            out_ev_nxt = pts_pkg::EV_IDLE;
          end
        end
      end

      pts_pkg::ST_SCAN: begin
        if (scan_take) begin
          best_pos_nxt  = idx_r;
          best_prio_nxt = rd_data_r.prio;
          best_id_nxt   = rd_data_r.id;
          best_rem_nxt  = rd_data_r.rem;
        end
        if (!scan_last) begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      pts_pkg::ST_UPDATE: begin
        out_sid_nxt = best_id_r;
        out_rem_nxt = dec_rem;
        if (upd_keep) begin
          wr_en         = 1'b1;
          wr_addr       = best_pos_r;
          wr_data.id    = best_id_r;
          wr_data.prio  = best_prio_r;
          wr_data.rem   = dec_rem;
          out_valid_nxt = 1'b1;
          out_ev_nxt    = pts_pkg::EV_SERVED;
        end else if (upd_tail) begin
          count_nxt     = last_pos;
          out_valid_nxt = 1'b1;
          out_ev_nxt    = pts_pkg::EV_FINISHED;
        end else begin
          // close up: entry best+1 is read now, lands in best next cycle
          idx_nxt = best_pos_r;
          rd_addr = best_pos_r + AW'(1);
        end
      end

      pts_pkg::ST_SHIFT: begin
        out_sid_nxt = best_id_r;
        wr_en       = 1'b1;
        wr_addr     = idx_r;
        wr_data     = rd_data_r;
        rd_addr     = idx_r + AW'(1) + AW'(1);
        if (shift_last) begin
          count_nxt     = last_pos;
          out_valid_nxt = 1'b1;
          out_ev_nxt    = pts_pkg::EV_FINISHED;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      default: ;
    endcase

    out_occ_nxt = pts_pkg::OCC_W'(count_nxt);
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pts_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    best_pos_r  <= best_pos_nxt;
    best_prio_r <= best_prio_nxt;
    best_id_r   <= best_id_nxt;
    best_rem_r  <= best_rem_nxt;
    out_ev_r    <= out_ev_nxt;
    out_sid_r   <= out_sid_nxt;
    out_rem_r   <= out_rem_nxt;
    out_occ_r   <= out_occ_nxt;
  end

  // task table
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // outputs
  // ---------------------------------------------------------------------------
  assign busy                 = (state_r != pts_pkg::ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_event_res        = out_ev_r;
  assign out_served_id        = out_sid_r;
  assign out_remaining_cycles = out_rem_r;
  assign out_occupancy        = out_occ_r;

endmodule

>>> rtl/core/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker: port-level checks for the priority tick scheduler
// Watches the command and result ports and flags words that break the
// result rules.
// ----------------------------------------------------------------------------
module pts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_command,
  input logic                        out_valid,
  input logic [pts_pkg::EV_W-1:0]    out_event_res,
  input logic [pts_pkg::ID_W-1:0]    out_served_id,
  input logic [pts_pkg::CYC_W-1:0]   out_remaining_cycles,
  input logic [pts_pkg::OCC_W-1:0]   out_occupancy
);

  // an add is answered in the very next cycle
  a_add_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == pts_pkg::CMD_ADD)) |=> out_valid)
    else $error("add word not answered in next cycle");

  // a long tick starts with no result word in its first busy cycle
  a_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result word on entry to a multi-cycle tick");

  // idle ticks only on an empty table, with zero payload
  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res == pts_pkg::EV_IDLE)) |->
      ((out_occupancy == '0) && (out_served_id == '0) && (out_remaining_cycles == '0)))
    else $error("idle word with nonzero fields");

  // served keeps cycles left, finished leaves none
  a_serve_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_event_res == pts_pkg::EV_SERVED) && (out_remaining_cycles == '0)
      || (out_event_res == pts_pkg::EV_FINISHED) && (out_remaining_cycles != '0))) |-> 1'b0)
    else $error("remaining cycles disagree with event");

  // add results carry no served task
  a_add_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_event_res == pts_pkg::EV_ADDED)
      || (out_event_res == pts_pkg::EV_REJECTED))) |->
      ((out_served_id == '0) && (out_remaining_cycles == '0)))
    else $error("add result with served fields set");

endmodule

bind priority_tick_scheduler pts_checker u_pts_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .in_command           (in_command),
  .out_valid            (out_valid),
  .out_event_res        (out_event_res),
  .out_served_id        (out_served_id),
  .out_remaining_cycles (out_remaining_cycles),
  .out_occupancy        (out_occupancy)
);
